// ----- hdl/keyboard_controller_ports_assert.svh -----
// Assertion macros used by the keyboard controller RTL.
`ifndef KEYBOARD_CONTROLLER_PORTS_ASSERT_SVH
`define KEYBOARD_CONTROLLER_PORTS_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define KBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keyboard controller assertion failed");

// Check that a condition in one cycle implies another in the next.
`define KBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyboard controller sequence assertion failed");

`endif

// ----- hdl/kbc_pkg.sv -----
// Types, constants and codes for the keyboard controller.
`timescale 1ns / 1ps
`default_nettype none

package kbc_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INJECT = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PEND_NONE    = 3'b001,
    PEND_CONFIG  = 3'b010,
    PEND_OUTPORT = 3'b100
  } pend_e;

  localparam logic [15:0] PORT_DATA = 16'h0060;
  localparam logic [15:0] PORT_CMD  = 16'h0064;

  localparam logic [7:0] CMD_RD_CFG     = 8'h20;
  localparam logic [7:0] CMD_WR_CFG     = 8'h60;
  localparam logic [7:0] CMD_VERSION    = 8'hA1;
  localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CMD_KBD_TEST   = 8'hAB;
  localparam logic [7:0] CMD_KBD_DIS    = 8'hAD;
  localparam logic [7:0] CMD_KBD_EN     = 8'hAE;
  localparam logic [7:0] CMD_RD_INPORT  = 8'hC0;
  localparam logic [7:0] CMD_WR_OUTPORT = 8'hD1;

  localparam logic [7:0] BYTE_ACK       = 8'hFA;
  localparam logic [7:0] BYTE_BAT_OK    = 8'hAA;
  localparam logic [7:0] BYTE_TEST_OK   = 8'h55;
  localparam logic [7:0] BYTE_KBD_OK    = 8'h00;
  localparam logic [7:0] BYTE_VERSION   = 8'h4E;
  localparam logic [7:0] BYTE_INPORT    = 8'hA0;
  localparam logic [7:0] BYTE_KBD_RESET = 8'hFF;
  localparam logic [7:0] BYTE_UNMAPPED  = 8'hFF;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
    logic [7:0]  key_byte;
    logic        key_last;
    logic        key_irq;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic       gate_level;
  } out_item_t;

  // FIFO update requested by the controller for one beat.
  typedef struct packed {
    logic             pop;
    logic             push0;
    logic             push1;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [CNT_W-1:0] count;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       shift;
    logic       load;
    logic [7:0] load_data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/kbc_cell.sv -----
// One FIFO cell: holds a byte, loads a new one or takes its neighbour's on a pop.
`timescale 1ns / 1ps
`default_nettype none

module kbc_cell (
  input  wire logic                clk_i,
  input  wire kbc_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]          next_i,
  output logic [7:0]               data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = ctrl_i.load_data;
    end else if (ctrl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hdl/kbc_ctrl.sv -----
// Port decode, command handling and controller state for the keyboard controller.
`timescale 1ns / 1ps
`default_nettype none

module kbc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire kbc_pkg::in_item_t item_i,
  input  wire logic [7:0]        head_i,
  output kbc_pkg::fifo_ctrl_t    fifo_o,
  output kbc_pkg::out_item_t     result_o
);

  localparam int CW = kbc_pkg::CNT_W;

  logic [CW-1:0]   count_q, count_d;
  logic [7:0]      last_q, last_d;
  logic            ws_q, ws_d;
  logic            sys_q, sys_d;
  kbc_pkg::pend_e  pend_q, pend_d;
  logic [7:0]      cfg_q, cfg_d;
  logic            a20_q, a20_d;

  logic            pop;
  logic [1:0]      npush;
  logic [7:0]      byte0, byte1;
  logic [7:0]      rd;
  logic            irq;
  logic            push0, push1;
  logic            status_rd;

  always_comb begin
    last_d    = last_q;
    ws_d      = ws_q;
    sys_d     = sys_q;
    pend_d    = pend_q;
    cfg_d     = cfg_q;
    a20_d     = a20_q;
    pop       = 1'b0;
    npush     = 2'd0;
    byte0     = kbc_pkg::BYTE_ACK;
    byte1     = kbc_pkg::BYTE_BAT_OK;
    rd        = 8'h00;
    irq       = 1'b0;
    status_rd = 1'b0;

    case (item_i.opcode)
      kbc_pkg::OP_READ: begin
        if (item_i.port_addr == kbc_pkg::PORT_DATA) begin
          if (count_q != '0) begin
            pop    = 1'b1;
            last_d = head_i;
          end
          rd  = last_d;
          irq = (count_q > CW'(1));
        end else if (item_i.port_addr == kbc_pkg::PORT_CMD) begin
          status_rd = 1'b1;
          rd   = {3'b000, 1'b1, 1'b0, sys_q, ws_q, (count_q != '0)};
          ws_d = 1'b0;
        end else begin
          rd = kbc_pkg::BYTE_UNMAPPED;
        end
      end
      kbc_pkg::OP_WRITE: begin
        if (item_i.port_addr == kbc_pkg::PORT_DATA) begin
          ws_d = 1'b1;
          case (pend_q)
            kbc_pkg::PEND_CONFIG:  cfg_d = item_i.write_data;
            kbc_pkg::PEND_OUTPORT: a20_d = item_i.write_data[1];
            default: begin
              irq   = 1'b1;
              npush = (item_i.write_data == kbc_pkg::BYTE_KBD_RESET) ? 2'd2 : 2'd1;
            end
          endcase
          pend_d = kbc_pkg::PEND_NONE;
        end else if (item_i.port_addr == kbc_pkg::PORT_CMD) begin
          ws_d = 1'b1;
          case (item_i.write_data)
            kbc_pkg::CMD_RD_CFG: begin
              npush = 2'd1;
              byte0 = cfg_q;
            end
            kbc_pkg::CMD_WR_CFG: pend_d = kbc_pkg::PEND_CONFIG;
            kbc_pkg::CMD_VERSION: begin
              npush = 2'd1;
              byte0 = kbc_pkg::BYTE_VERSION;
            end
            kbc_pkg::CMD_SELF_TEST: begin
              sys_d = 1'b1;
              npush = 2'd1;
              byte0 = kbc_pkg::BYTE_TEST_OK;
            end
            kbc_pkg::CMD_KBD_TEST: begin
              npush = 2'd1;
              byte0 = kbc_pkg::BYTE_KBD_OK;
            end
            kbc_pkg::CMD_KBD_DIS: ;
            kbc_pkg::CMD_KBD_EN: begin
              npush = 2'd1;
              byte0 = kbc_pkg::BYTE_ACK;
            end
            kbc_pkg::CMD_RD_INPORT: begin
              npush = 2'd1;
              byte0 = kbc_pkg::BYTE_INPORT;
            end
            kbc_pkg::CMD_WR_OUTPORT: pend_d = kbc_pkg::PEND_OUTPORT;
            default: pend_d = kbc_pkg::PEND_NONE;
          endcase
        end
      end
      kbc_pkg::OP_INJECT: begin
        npush = 2'd1;
        byte0 = item_i.key_byte;
        irq   = item_i.key_last & item_i.key_irq;
      end
      default: ;
    endcase
  end

  // Drop bytes that do not fit; pops and pushes never share a beat.
  assign push0 = accept_i && (npush != 2'd0) && (count_q < CW'(kbc_pkg::FIFO_DEPTH));
  assign push1 = accept_i && (npush == 2'd2) &&
                 ((count_q + CW'(1)) < CW'(kbc_pkg::FIFO_DEPTH));

  assign count_d = count_q - CW'(accept_i && pop) + CW'(push0) + CW'(push1);

  assign fifo_o.pop   = accept_i && pop;
  assign fifo_o.push0 = push0;
  assign fifo_o.push1 = push1;
  assign fifo_o.byte0 = byte0;
  assign fifo_o.byte1 = byte1;
  assign fifo_o.count = count_q;

  assign result_o.read_data   = rd;
  assign result_o.irq_request = irq;
  assign result_o.gate_level  = a20_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= 8'h00;
      ws_q    <= 1'b0;
      sys_q   <= 1'b0;
      pend_q  <= kbc_pkg::PEND_NONE;
      cfg_q   <= 8'h00;
      a20_q   <= 1'b0;
    end else if (accept_i) begin
      count_q <= count_d;
      last_q  <= last_d;
      ws_q    <= ws_d;
      sys_q   <= sys_d;
      pend_q  <= pend_d;
      cfg_q   <= cfg_d;
      a20_q   <= a20_d;
    end
  end

`include "keyboard_controller_ports_assert.svh"

  `KBC_ASSERT(a_count_bound, count_q <= CW'(kbc_pkg::FIFO_DEPTH))
  `KBC_ASSERT(a_pop_nonempty, !fifo_o.pop || (count_q != '0))
  `KBC_ASSERT(a_push_order, !push1 || push0)
  `KBC_ASSERT(a_no_pop_push, !(fifo_o.pop && push0))
  `KBC_ASSERT_NEXT(a_status_clears_ws, accept_i && status_rd, !ws_q)

endmodule

`default_nettype wire

// ----- hdl/keyboard_controller_ports.sv -----
// Top level of the keyboard controller: cell chain FIFO, controller and output skid.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------
//  in      | in  | in_valid_i / in_ready_o | in_item_i  (port access)
//  out     | out | out_valid_o/out_ready_i | out_item_o (one per beat)
//
// One item is accepted per cycle while the skid stage is empty; its result is registered in the output stage,
// or in the skid stage when the output is stalled. The rate is set by the combinational decode and the cell
// chain FIFO, which shifts one place per pop and loads up to two bytes per beat.
// Reset clears the controller state and the fill count; cell contents stay
// undefined until written and need no clearing pass.
// A stalled output holds its beat; one more beat parks in the skid stage.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_controller_ports (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire kbc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output kbc_pkg::out_item_t      out_item_o
);

  localparam int DEPTH = kbc_pkg::FIFO_DEPTH;
  localparam int CW    = kbc_pkg::CNT_W;

  logic                 accept;
  kbc_pkg::fifo_ctrl_t  fifo_ctrl;
  kbc_pkg::out_item_t   result;
  kbc_pkg::cell_ctrl_t  cell_ctrl [DEPTH];
  logic [7:0]           cell_q    [DEPTH];
  logic [7:0]           cell_next [DEPTH];

  kbc_pkg::out_item_t   out_q, skid_q;
  logic                 out_valid_q, skid_valid_q;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  kbc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .head_i   (cell_q[0]),
    .fifo_o   (fifo_ctrl),
    .result_o (result)
  );

  // Cell zero is the head; a pop moves every byte one cell towards it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic ld0, ld1;

    assign ld0 = fifo_ctrl.push0 && (fifo_ctrl.count == CW'(i));
    assign ld1 = fifo_ctrl.push1 && ((fifo_ctrl.count + CW'(1)) == CW'(i));

    assign cell_ctrl[i].shift     = fifo_ctrl.pop;
    assign cell_ctrl[i].load      = ld0 || ld1;
    assign cell_ctrl[i].load_data = ld0 ? fifo_ctrl.byte0 : fifo_ctrl.byte1;

    if (i == DEPTH - 1) begin : g_tail
      assign cell_next[i] = 8'h00;
    end else begin : g_link
      assign cell_next[i] = cell_q[i+1];
    end

    kbc_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .next_i (cell_next[i]),
      .data_o (cell_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (accept) begin
        skid_q <= result;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/kbc_checker.sv -----
// Checker for the keyboard controller: predicts every result beat and compares it.
`timescale 1ns / 1ps

module kbc_checker
  import kbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        results_due_o,
  output int        results_seen_o
);

  // Controller state as the host sees it.
  logic [7:0] host_bytes[$];
  logic [7:0] last_byte;
  logic       write_seen;
  logic       sys_flag;
  pend_e      pend;
  logic [7:0] ctrl_cfg;
  logic       a20;

  out_item_t  due_q[$];
  out_item_t  want;
  int         fails;
  int         seen;

  // Drop the byte when the queue is full.
  function automatic void queue_byte(logic [7:0] b);
    if (host_bytes.size() < FIFO_DEPTH) host_bytes.push_back(b);
  endfunction

  function automatic out_item_t predict_access(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.opcode)
      OP_READ: begin
        if (it.port_addr == PORT_DATA) begin
          if (host_bytes.size() > 0) last_byte = host_bytes.pop_front();
          r.read_data   = last_byte;
          r.irq_request = host_bytes.size() > 0;
        end else if (it.port_addr == PORT_CMD) begin
          r.read_data = {3'b000, 1'b1, 1'b0, sys_flag, write_seen, host_bytes.size() > 0};
          write_seen  = 1'b0;
        end else begin
          r.read_data = BYTE_UNMAPPED;
        end
      end
      OP_WRITE: begin
        if (it.port_addr == PORT_DATA) begin
          write_seen = 1'b1;
          case (pend)
            PEND_CONFIG: ctrl_cfg = it.write_data;
            PEND_OUTPORT: a20 = it.write_data[1];
            default: begin
              queue_byte(BYTE_ACK);
              r.irq_request = 1'b1;
              if (it.write_data == BYTE_KBD_RESET) queue_byte(BYTE_BAT_OK);
            end
          endcase
          pend = PEND_NONE;
        end else if (it.port_addr == PORT_CMD) begin
          write_seen = 1'b1;
          case (it.write_data)
            CMD_RD_CFG: queue_byte(ctrl_cfg);
            CMD_WR_CFG: pend = PEND_CONFIG;
            CMD_VERSION: queue_byte(BYTE_VERSION);
            CMD_SELF_TEST: begin
              sys_flag = 1'b1;
              queue_byte(BYTE_TEST_OK);
            end
            CMD_KBD_TEST: queue_byte(BYTE_KBD_OK);
            CMD_KBD_DIS: ;
            CMD_KBD_EN: queue_byte(BYTE_ACK);
            CMD_RD_INPORT: queue_byte(BYTE_INPORT);
            CMD_WR_OUTPORT: pend = PEND_OUTPORT;
            default: pend = PEND_NONE;
          endcase
        end
      end
      OP_INJECT: begin
        queue_byte(it.key_byte);
        r.irq_request = it.key_last & it.key_irq;
      end
      default: ;
    endcase
    r.gate_level = a20;
    return r;
  endfunction

  task automatic report(string field, logic [7:0] exp_val, logic [7:0] act_val);
    fails++;
    $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_bytes.delete();
      due_q.delete();
      last_byte  = '0;
      write_seen = 1'b0;
      sys_flag   = 1'b0;
      pend       = PEND_NONE;
      ctrl_cfg   = '0;
      a20        = 1'b0;
      fails      = 0;
      seen       = 0;
    end else begin
      // Retire the result beat first; a beat accepted now cannot answer this edge.
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t ns: result beat %p arrived with nothing outstanding", $time, out_item_i);
        end else begin
          want = due_q.pop_front();
          if (out_item_i.read_data !== want.read_data)
            report("read_data", want.read_data, out_item_i.read_data);
          if (out_item_i.irq_request !== want.irq_request)
            report("irq_request", want.irq_request, out_item_i.irq_request);
          if (out_item_i.gate_level !== want.gate_level)
            report("gate_level", want.gate_level, out_item_i.gate_level);
        end
      end
      if (in_valid_i && in_ready_i) due_q.push_back(predict_access(in_item_i));
    end
    fail_count_o   <= fails;
    results_due_o  <= due_q.size();
    results_seen_o <= seen;
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the keyboard controller: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import kbc_pkg::*;

  localparam logic [7:0] REPLY_CMDS [7] = '{CMD_RD_CFG, CMD_VERSION, CMD_SELF_TEST,
                                            CMD_KBD_TEST, CMD_KBD_DIS, CMD_KBD_EN,
                                            CMD_RD_INPORT};

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int fails, due, seen;
  int idle_pct, stall_pct;
  logic hold_req;
  int hold_left;
  int n_items, n_rd, n_wr, n_key, n_nop;

  always #6 clk_i = ~clk_i;

  keyboard_controller_ports u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  kbc_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_item_i     (out_item),
    .fail_count_o   (fails),
    .results_due_o  (due),
    .results_seen_o (seen)
  );

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  function automatic in_item_t fill_item(op_e op);
    in_item_t it;
    it.opcode     = op;
    it.port_addr  = 16'($urandom);
    it.write_data = 8'($urandom);
    it.key_byte   = 8'($urandom);
    it.key_last   = 1'($urandom);
    it.key_irq    = 1'($urandom);
    return it;
  endfunction

  task automatic put(in_item_t it);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    n_items++;
    case (it.opcode)
      OP_READ:   n_rd++;
      OP_WRITE:  n_wr++;
      OP_INJECT: n_key++;
      default:   n_nop++;
    endcase
  endtask

  task automatic rd(logic [15:0] port);
    in_item_t it;
    it = fill_item(OP_READ);
    it.port_addr = port;
    put(it);
  endtask

  task automatic wr(logic [15:0] port, logic [7:0] data);
    in_item_t it;
    it = fill_item(OP_WRITE);
    it.port_addr  = port;
    it.write_data = data;
    put(it);
  endtask

  task automatic inj(logic [7:0] b, logic last, logic irq);
    in_item_t it;
    it = fill_item(OP_INJECT);
    it.key_byte = b;
    it.key_last = last;
    it.key_irq  = irq;
    put(it);
  endtask

  // Hold the input low until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (due != 0);
  endtask

  task automatic drain_bytes();
    repeat (FIFO_DEPTH + 2) rd(PORT_DATA);
  endtask

  task automatic random_sequence();
    int pick, n, sel;
    logic [7:0] b;
    in_item_t it;
    pick = $urandom_range(99);
    if (pick < 15) begin
      wr(PORT_CMD, REPLY_CMDS[$urandom_range(6)]);
      if ($urandom_range(1)) rd(PORT_CMD);
      rd(PORT_DATA);
    end else if (pick < 25) begin
      wr(PORT_CMD, CMD_WR_CFG);
      wr(PORT_DATA, 8'($urandom));
      wr(PORT_CMD, CMD_RD_CFG);
      rd(PORT_DATA);
    end else if (pick < 35) begin
      wr(PORT_CMD, CMD_WR_OUTPORT);
      wr(PORT_DATA, 8'($urandom));
      if ($urandom_range(1)) rd(PORT_CMD);
    end else if (pick < 45) begin
      b = ($urandom_range(3) == 0) ? BYTE_KBD_RESET : 8'($urandom);
      wr(PORT_DATA, b);
      repeat ($urandom_range(1, 3)) rd(PORT_DATA);
    end else if (pick < 60) begin
      n = $urandom_range(1, 4);
      for (int i = 1; i <= n; i++) inj(8'($urandom), i == n, 1'($urandom));
      repeat (n) rd(PORT_DATA);
    end else if (pick < 68) begin
      repeat ($urandom_range(1, 2)) rd(PORT_CMD);
    end else if (pick < 73) begin
      repeat ($urandom_range(12, 20)) inj(8'($urandom), 1'($urandom), 1'($urandom));
      drain_bytes();
    end else if (pick < 83) begin
      // Broken sequence: a two-byte command interrupted before its data byte.
      wr(PORT_CMD, $urandom_range(1) ? CMD_WR_CFG : CMD_WR_OUTPORT);
      sel = $urandom_range(3);
      if (sel == 0) wr(PORT_CMD, 8'($urandom));
      else if (sel == 1) wr(16'($urandom), 8'($urandom));
      else if (sel == 2) rd(PORT_DATA);
      else inj(8'($urandom), 1'($urandom), 1'($urandom));
      wr(PORT_DATA, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        it = fill_item(op_e'($urandom_range(3)));
        sel = $urandom_range(9);
        if (sel < 4) it.port_addr = PORT_DATA;
        else if (sel < 8) it.port_addr = PORT_CMD;
        put(it);
      end
    end
  endtask

  initial begin
    in_item_t it;
    int phase;
    bit held, paused;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    hold_req  = 1'b0;
    hold_left = 0;
    idle_pct  = 0;
    stall_pct = 0;
    held      = 1'b0;
    paused    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset status, empty data read, unmapped ports and the no-op.
    rd(PORT_CMD);
    rd(PORT_DATA);
    rd(16'hFFFF);
    wr(16'h0000, 8'hFF);
    it = '1;
    it.opcode = OP_NOP;
    put(it);
    // Config write, A20 high, then a pending command cancelled by an unknown one.
    wr(PORT_CMD, CMD_WR_CFG);
    wr(PORT_DATA, 8'hFF);
    wr(PORT_CMD, CMD_WR_OUTPORT);
    wr(PORT_DATA, 8'hFF);
    wr(PORT_CMD, CMD_WR_OUTPORT);
    wr(PORT_CMD, 8'h00);
    wr(PORT_DATA, BYTE_KBD_RESET);
    // Every reply command, then key bytes with and without the last marker.
    wr(PORT_CMD, CMD_SELF_TEST);
    wr(PORT_CMD, CMD_VERSION);
    wr(PORT_CMD, CMD_KBD_TEST);
    wr(PORT_CMD, CMD_KBD_DIS);
    wr(PORT_CMD, CMD_KBD_EN);
    wr(PORT_CMD, CMD_RD_INPORT);
    wr(PORT_CMD, CMD_RD_CFG);
    inj(8'hFF, 1'b0, 1'b1);
    inj(8'h00, 1'b1, 1'b1);
    // Fill the queue, then overflow it; the interrupt still fires.
    repeat (3) wr(PORT_DATA, BYTE_KBD_RESET);
    inj(8'h5A, 1'b1, 1'b1);
    rd(PORT_CMD);
    drain_bytes();
    wr(PORT_CMD, CMD_WR_OUTPORT);
    wr(PORT_DATA, 8'h00);

    while (n_items < 1370) begin
      phase = (n_items / 120) % 4;
      idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 12 : 0;
      stall_pct <= (phase == 2) ? 46 : (phase == 3) ? 12 : 0;
      if (!held && n_items >= 700) begin
        // Long receiver hold-off while key bytes keep coming.
        held = 1'b1;
        hold_req <= 1'b1;
        repeat (24) inj(8'($urandom), 1'($urandom), 1'($urandom));
      end
      if (!paused && n_items >= 1000) begin
        paused = 1'b1;
        wait_drained();
      end
      random_sequence();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Drove %0d beats (%0d reads, %0d writes, %0d key bytes, %0d no-ops)",
             n_items, n_rd, n_wr, n_key, n_nop);
    $display("Checked %0d results across four idle mixes, a long hold-off and a full drain",
             seen);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/kbc_pkg.sv
hdl/kbc_cell.sv
hdl/kbc_ctrl.sv
hdl/keyboard_controller_ports.sv
tb/sv/kbc_checker.sv
tb/sv/tb.sv
